[rtl/core/sqfm_pkg.sv]
// Shared types, constants and codes of the suffix quality and fetch margin unit.
`timescale 1ns / 1ps
package sqfm_pkg;

  localparam int QBITS = 16;
  localparam int TBITS = 16;
  localparam logic [16:0] QUAL_ONE = 17'(1 << QBITS);
  localparam logic [39:0] BPS_RESET = 40'd1250000;
  localparam logic [16:0] PERIOD_RESET = 17'd2731;
  localparam logic [47:0] SQSUM_MAX = 48'hFFFF_FFFF_FFFF;
  localparam logic signed [48:0] SLACK_MAX = 49'sh0_7FFF_FFFF_FFFF;

  localparam logic [0:0] REG_BPS = 1'b0;
  localparam logic [0:0] REG_PERIOD = 1'b1;

  typedef struct packed {
    logic        track_start;
    logic [16:0] quality;
    logic        shown;
    logic [31:0] frame_length;
    logic        cached;
  } in_item_t;

  typedef struct packed {
    logic [16:0] average_quality;
    logic [16:0] stddev_quality;
    logic [16:0] minimum_quality;
    logic [31:0] fetch_time;
    logic [31:0] margin_required;
  } out_item_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } div_state_t;

  typedef enum logic [3:0] {
    SQ_IDLE,
    SQ_MEAN_DIV,
    SQ_MEAN_UPD,
    SQ_PROD,
    SQ_VAR_DIV,
    SQ_ROOT,
    SQ_FETCH_DIV,
    SQ_SLACK,
    SQ_OUT
  } seq_state_t;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [39:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quotient;
  } div_rsp_t;

endpackage

[rtl/core/sqfm_divider.sv]
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module sqfm_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  sqfm_pkg::div_req_t req,
  output sqfm_pkg::div_rsp_t rsp
);

  sqfm_pkg::div_state_t state_r, state_nxt;
  logic [63:0] quo_r, quo_nxt;
  logic [40:0] rem_r, rem_nxt;
  logic [39:0] dvs_r, dvs_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [40:0] trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sqfm_pkg::DIV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sqfm_pkg::DIV_IDLE: if (req.start) state_nxt = sqfm_pkg::DIV_RUN;
      sqfm_pkg::DIV_RUN:  if (cnt_r == 6'd63) state_nxt = sqfm_pkg::DIV_DONE;
      sqfm_pkg::DIV_DONE: state_nxt = sqfm_pkg::DIV_IDLE;
      default:            state_nxt = sqfm_pkg::DIV_IDLE;
    endcase
  end

  always_comb begin
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    dvs_nxt = dvs_r;
    cnt_nxt = cnt_r;
    trial = {rem_r[39:0], quo_r[63]};
    unique case (state_r)
      sqfm_pkg::DIV_IDLE: begin
        quo_nxt = req.dividend;
        rem_nxt = '0;
        dvs_nxt = req.divisor;
        cnt_nxt = '0;
      end
      sqfm_pkg::DIV_RUN: begin
        if (trial >= {1'b0, dvs_r}) begin
          rem_nxt = trial - {1'b0, dvs_r};
          quo_nxt = {quo_r[62:0], 1'b1};
        end else begin
          rem_nxt = trial;
          quo_nxt = {quo_r[62:0], 1'b0};
        end
        cnt_nxt = cnt_r + 6'd1;
      end
      default: ;
    endcase
  end

  assign rsp.done = (state_r == sqfm_pkg::DIV_DONE);
  assign rsp.quotient = quo_r;

endmodule

[rtl/core/sqfm_sqrt.sv]
// Bit-pair integer square root, one result bit per cycle.
`timescale 1ns / 1ps
module sqfm_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [47:0] radicand,
  output logic        done,
  output logic [23:0] root
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [47:0] val_r, val_nxt;
  logic [25:0] rem_r, rem_nxt;
  logic [23:0] res_r, res_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [25:0] trial, test;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    val_r <= val_nxt;
    rem_r <= rem_nxt;
    res_r <= res_nxt;
    cnt_r <= cnt_nxt;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    val_nxt = val_r;
    rem_nxt = rem_r;
    res_nxt = res_r;
    cnt_nxt = cnt_r;
    trial = {rem_r[23:0], val_r[47:46]};
    test = {res_r, 2'b01};
    if (!busy_r) begin
      if (start) begin
        busy_nxt = 1'b1;
        val_nxt = radicand;
        rem_nxt = '0;
        res_nxt = '0;
        cnt_nxt = '0;
      end
    end else begin
      val_nxt = {val_r[45:0], 2'b00};
      if (trial >= test) begin
        rem_nxt = trial - test;
        res_nxt = {res_r[22:0], 1'b1};
      end else begin
        rem_nxt = trial;
        res_nxt = {res_r[22:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd23) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  assign done = done_r;
  assign root = res_r;

endmodule

[rtl/core/sqfm_regs.sv]
// Configuration registers behind the APB-style port.
`timescale 1ns / 1ps
module sqfm_regs (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:3]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic [39:0] bps,
  output logic [16:0] period
);

  logic [39:0] bps_r;
  logic [16:0] period_r;
  logic        wr;

  assign wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bps_r <= sqfm_pkg::BPS_RESET;
      period_r <= sqfm_pkg::PERIOD_RESET;
    end else if (wr) begin
      if (cfg_paddr == sqfm_pkg::REG_BPS) bps_r <= cfg_pwdata[39:0];
      else period_r <= cfg_pwdata[16:0];
    end
  end

  always_comb begin
    if (cfg_paddr == sqfm_pkg::REG_BPS) cfg_prdata = {24'd0, bps_r};
    else cfg_prdata = {47'd0, period_r};
  end

  assign bps = bps_r;
  assign period = period_r;

endmodule

[rtl/core/suffix_quality_and_fetch_margin_unit.sv]
// Top level: sequencer around a shared divider and a square root unit.
`timescale 1ns / 1ps
// One frame is taken per transfer and yields one result. The shared 64-step
// divider runs up to three passes: the mean step for a shown frame after the
// first, the variance once two frames are shown, and the fetch time unless the
// frame is cached or the rate is zero. The 24-step square root runs after the
// variance. Ready drops from the input transfer until the result is taken.
// Registers: bytes_per_second at byte 0, frame_period at byte 8, 64-bit data.
module suffix_quality_and_fetch_margin_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sqfm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sqfm_pkg::out_item_t out_data,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [3:3]          cfg_paddr,
  input  logic [63:0]         cfg_pwdata,
  output logic [63:0]         cfg_prdata,
  output logic                cfg_pready
);

  sqfm_pkg::seq_state_t state_r, state_nxt;
  sqfm_pkg::div_req_t   dreq;
  sqfm_pkg::div_rsp_t   drsp;
  logic [39:0] bps;
  logic [16:0] period;

  logic [31:0] count_r, count_nxt;
  logic [16:0] mean_r, mean_nxt;
  logic [47:0] sqsum_r, sqsum_nxt;
  logic [16:0] min_r, min_nxt;
  logic signed [48:0] slack_r, slack_nxt;
  sqfm_pkg::in_item_t item_r, item_nxt;
  logic        neg_r, neg_nxt;
  logic [16:0] mag_r, mag_nxt;
  logic [16:0] sd_r, sd_nxt;
  logic [31:0] fetch_r, fetch_nxt;
  sqfm_pkg::out_item_t res_r, res_nxt;
  logic        busy_r, busy_nxt;
  logic        sq_start;
  logic        sq_done;
  logic [23:0] sq_root;
  logic [47:0] var_q;
  logic [16:0] q_sat, step, nm, bdiff;
  logic [33:0] prod;
  logic [48:0] sqsum_add;
  logic signed [48:0] s;
  logic [31:0] margin;

  assign cfg_pready = 1'b1;

  sqfm_regs u_regs (
    .clk, .rst_n, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr,
    .cfg_pwdata, .cfg_prdata, .bps, .period
  );

  sqfm_divider u_div (.clk, .rst_n, .req(dreq), .rsp(drsp));

  sqfm_sqrt u_sqrt (
    .clk, .rst_n, .start(sq_start), .radicand(var_q), .done(sq_done), .root(sq_root)
  );

  assign var_q = drsp.quotient[47:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sqfm_pkg::SQ_IDLE;
      count_r <= '0;
      mean_r <= '0;
      sqsum_r <= '0;
      min_r <= sqfm_pkg::QUAL_ONE;
      slack_r <= '0;
      busy_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      mean_r <= mean_nxt;
      sqsum_r <= sqsum_nxt;
      min_r <= min_nxt;
      slack_r <= slack_nxt;
      busy_r <= busy_nxt;
    end
    item_r <= item_nxt;
    neg_r <= neg_nxt;
    mag_r <= mag_nxt;
    sd_r <= sd_nxt;
    fetch_r <= fetch_nxt;
    res_r <= res_nxt;
  end

  assign in_ready = (state_r == sqfm_pkg::SQ_IDLE);
  assign out_valid = (state_r == sqfm_pkg::SQ_OUT);
  assign out_data = res_r;

  assign q_sat = (in_data.quality > sqfm_pkg::QUAL_ONE) ? sqfm_pkg::QUAL_ONE
                                                         : in_data.quality;
  assign step = drsp.quotient[16:0];
  assign nm = neg_r ? (mean_r - step) : (mean_r + step);
  assign bdiff = neg_r ? (nm - item_r.quality) : (item_r.quality - nm);
  assign prod = mag_r * bdiff;
  assign sqsum_add = {1'b0, sqsum_r} + {15'd0, prod};
  assign s = slack_r + $signed({17'd0, fetch_r});
  assign margin = (s < 0) ? 32'd0 : ((s > 49'sh0_FFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0]);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sqfm_pkg::SQ_IDLE: begin
        if (in_valid) begin
          if (!in_data.shown || count_nxt == 32'd1) begin
            state_nxt = sqfm_pkg::SQ_PROD;
          end else begin
            state_nxt = sqfm_pkg::SQ_MEAN_DIV;
          end
        end
      end
      sqfm_pkg::SQ_MEAN_DIV: if (drsp.done) state_nxt = sqfm_pkg::SQ_MEAN_UPD;
      sqfm_pkg::SQ_MEAN_UPD: state_nxt = sqfm_pkg::SQ_PROD;
      sqfm_pkg::SQ_PROD: begin
        if (count_r > 32'd1) state_nxt = sqfm_pkg::SQ_VAR_DIV;
        else state_nxt = sqfm_pkg::SQ_FETCH_DIV;
      end
      sqfm_pkg::SQ_VAR_DIV: if (drsp.done) state_nxt = sqfm_pkg::SQ_ROOT;
      sqfm_pkg::SQ_ROOT: if (sq_done) state_nxt = sqfm_pkg::SQ_FETCH_DIV;
      sqfm_pkg::SQ_FETCH_DIV: begin
        if (item_r.cached || bps == 40'd0 || drsp.done) state_nxt = sqfm_pkg::SQ_SLACK;
      end
      sqfm_pkg::SQ_SLACK: state_nxt = sqfm_pkg::SQ_OUT;
      sqfm_pkg::SQ_OUT: if (out_ready) state_nxt = sqfm_pkg::SQ_IDLE;
      default: state_nxt = sqfm_pkg::SQ_IDLE;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    mean_nxt = mean_r;
    sqsum_nxt = sqsum_r;
    min_nxt = min_r;
    slack_nxt = slack_r;
    item_nxt = item_r;
    neg_nxt = neg_r;
    mag_nxt = mag_r;
    sd_nxt = sd_r;
    fetch_nxt = fetch_r;
    res_nxt = res_r;
    busy_nxt = 1'b0;
    sq_start = 1'b0;
    dreq.start = 1'b0;
    dreq.dividend = '0;
    dreq.divisor = '0;
    unique case (state_r)
      sqfm_pkg::SQ_IDLE: begin
        if (in_data.track_start) begin
          count_nxt = '0;
          mean_nxt = '0;
          sqsum_nxt = '0;
          min_nxt = sqfm_pkg::QUAL_ONE;
          slack_nxt = '0;
        end
        if (in_data.shown && count_nxt != 32'hFFFF_FFFF) count_nxt = count_nxt + 32'd1;
        if (in_valid) begin
          item_nxt = in_data;
          item_nxt.quality = q_sat;
          neg_nxt = q_sat < mean_nxt;
          mag_nxt = (q_sat < mean_nxt) ? (mean_nxt - q_sat) : (q_sat - mean_nxt);
          sd_nxt = '0;
          if (in_data.shown && count_nxt == 32'd1) begin
            mean_nxt = q_sat;
            min_nxt = q_sat;
            sqsum_nxt = '0;
          end
        end else begin
          count_nxt = count_r;
          mean_nxt = mean_r;
          sqsum_nxt = sqsum_r;
          min_nxt = min_r;
          slack_nxt = slack_r;
        end
      end
      sqfm_pkg::SQ_MEAN_DIV: begin
        dreq.start = !busy_r;
        busy_nxt = !drsp.done;
        dreq.dividend = {47'd0, mag_r} + {33'd0, count_r[31:1]};
        dreq.divisor = {8'd0, count_r};
      end
      sqfm_pkg::SQ_MEAN_UPD: begin
        mean_nxt = nm;
        sqsum_nxt = sqsum_add[48] ? sqfm_pkg::SQSUM_MAX
                  : ((sqsum_add[47:0] < sqsum_r) ? sqfm_pkg::SQSUM_MAX : sqsum_add[47:0]);
        if (item_r.quality < min_r) min_nxt = item_r.quality;
      end
      sqfm_pkg::SQ_VAR_DIV: begin
        dreq.start = !busy_r;
        busy_nxt = !drsp.done;
        dreq.dividend = {16'd0, sqsum_r};
        dreq.divisor = {8'd0, count_r - 32'd1};
        sq_start = drsp.done;
      end
      sqfm_pkg::SQ_ROOT: begin
        if (sq_done) begin
          sd_nxt = (sq_root > {7'd0, sqfm_pkg::QUAL_ONE}) ? sqfm_pkg::QUAL_ONE : sq_root[16:0];
        end
      end
      sqfm_pkg::SQ_FETCH_DIV: begin
        if (item_r.cached) begin
          fetch_nxt = '0;
        end else if (bps == 40'd0) begin
          fetch_nxt = 32'hFFFF_FFFF;
        end else begin
          dreq.start = !busy_r;
          busy_nxt = !drsp.done;
          dreq.dividend = {16'd0, item_r.frame_length, 16'd0};
          dreq.divisor = bps;
          if (drsp.done) begin
            fetch_nxt = (drsp.quotient[63:32] != 32'd0) ? 32'hFFFF_FFFF
                                                        : drsp.quotient[31:0];
          end
        end
      end
      sqfm_pkg::SQ_SLACK: begin
        slack_nxt = (s < 0) ? 49'sd0 : ((s > sqfm_pkg::SLACK_MAX) ? sqfm_pkg::SLACK_MAX : s);
        if (item_r.shown) slack_nxt = slack_nxt - $signed({32'd0, period});
        if (count_r == 32'd0) begin
          res_nxt.average_quality = sqfm_pkg::QUAL_ONE;
          res_nxt.minimum_quality = sqfm_pkg::QUAL_ONE;
        end else begin
          res_nxt.average_quality = mean_r;
          res_nxt.minimum_quality = min_r;
        end
        res_nxt.stddev_quality = sd_r;
        res_nxt.fetch_time = fetch_r;
        res_nxt.margin_required = margin;
      end
      default: ;
    endcase
  end

endmodule

[rtl/core/sqfm_checker.sv]
// Port-level checker for the suffix quality and fetch margin unit, with its bind.
`timescale 1ns / 1ps
module sqfm_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input sqfm_pkg::out_item_t out_data,
  input logic cfg_pready
);

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken while result pending");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("ready after transfer");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result dropped");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.stddev_quality <= sqfm_pkg::QUAL_ONE &&
                   out_data.minimum_quality <= out_data.average_quality))
    else $error("quality out of range");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready) else $error("pready low");

endmodule

bind suffix_quality_and_fetch_margin_unit sqfm_checker u_sqfm_checker (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_data, .cfg_pready
);
